FILE: design/xcrc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcrc_pkg: shared types and constants of the XMODEM-CRC receiver
// Control bytes, action and phase codes, the result item layout and the
// CRC-16 (poly 0x1021) byte update.
// ---------------------------------------------------------------------------
package xcrc_pkg;

  // Input action codes
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ERROR_LIMIT = 1'b0;
  localparam logic CFG_IMAGE_BASE  = 1'b1;

  // Protocol bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  // Receive phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_NUMBER = 3'd1;
  localparam logic [2:0] PH_COMPL  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;
  localparam logic [2:0] PH_CRC_LO = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_ABORT  = 3'd7;

  // Block sizes and checks
  localparam logic [10:0] SHORT_BLOCK   = 11'd128;
  localparam logic [10:0] LONG_BLOCK    = 11'd1024;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [8:0]  NUM_SUM       = 9'd255;
  localparam logic [7:0]  ERR_SATURATE  = 8'd255;
  localparam logic [7:0]  ERROR_LIMIT_RST = 8'd3;

  // One result item
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [31:0] data_address;
    logic        block_end;
    logic        block_good;
    logic        erase_request;
    logic        finished;
    logic        aborted;
    logic        last;
  } res_t;

  // CRC-16 update by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: design/xmodem_crc_receiver_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_unit: XMODEM-CRC / 1K receive engine
// Takes received bytes and timeouts, checks blocks and emits replies,
// payload bytes with flash addresses and transfer status.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per received byte,
//   receive timeout or session start (in_action).
//   Result channel (out_valid/out_ready): zero to three transactions per
//   input; out_last marks the final one of an input.
//   Config port (cfg_we/cfg_index/cfg_data): error limit and image base,
//   written while the block is idle; the base is loaded at session start.
// The first result of an input is registered in the result buffer on accept.
// Throughput: one input per cycle while each yields at most one result and
//   out_ready stays high; an input with more results holds off new inputs
//   while the single three-entry result buffer drains, one item per cycle.
// Reset (rst_n, synchronous): header phase, block number 1, error count 0,
//   error limit 3, image base 0, result buffer empty.
// A stalled receiver holds the buffer; in_ready drops until it drains.
// ---------------------------------------------------------------------------
module xmodem_crc_receiver_unit
  import xcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_data_address,
  output logic        out_block_end,
  output logic        out_block_good,
  output logic        out_erase_request,
  output logic        out_finished,
  output logic        out_aborted,
  output logic        out_last,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [7:0]  error_limit_r;
  logic [31:0] image_base_r;

  // Protocol state
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  expected_block_r, expected_block_nxt;
  logic [7:0]  got_number_r, got_number_nxt;
  logic [7:0]  got_complement_r, got_complement_nxt;
  logic        long_block_r, long_block_nxt;
  logic [10:0] byte_count_r, byte_count_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [15:0] sent_crc_r, sent_crc_nxt;
  logic [7:0]  error_count_r, error_count_nxt;
  logic        first_seen_r, first_seen_nxt;
  logic [31:0] write_address_r, write_address_nxt;

  // Result buffer: slot 0 is on the output
  res_t        slot_r [3];
  logic [1:0]  cnt_r, cnt_nxt;
  res_t        res [3];
  logic [1:0]  nres;

  logic        in_acc, out_acc;
  logic        is_byte;
  logic [10:0] blk_size;
  logic [10:0] count_inc;
  logic [15:0] sent_full;
  res_t        item;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign in_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  assign is_byte   = (in_action == ACT_BYTE);
  assign blk_size  = long_block_r ? LONG_BLOCK : SHORT_BLOCK;
  assign count_inc = byte_count_r + 11'd1;
  assign sent_full = {sent_crc_r[15:8], in_rx_byte};

  // Next state and result items of one input
  always_comb begin
    phase_nxt          = phase_r;
    expected_block_nxt = expected_block_r;
    got_number_nxt     = got_number_r;
    got_complement_nxt = got_complement_r;
    long_block_nxt     = long_block_r;
    byte_count_nxt     = byte_count_r;
    running_crc_nxt    = running_crc_r;
    sent_crc_nxt       = sent_crc_r;
    error_count_nxt    = error_count_r;
    first_seen_nxt     = first_seen_r;
    write_address_nxt  = write_address_r;
    nres               = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    item = '0;

    case (in_action)
      ACT_START: begin
        phase_nxt          = PH_HEADER;
        expected_block_nxt = 8'd1;
        got_number_nxt     = 8'd0;
        got_complement_nxt = 8'd0;
        long_block_nxt     = 1'b0;
        byte_count_nxt     = 11'd0;
        running_crc_nxt    = 16'd0;
        sent_crc_nxt       = 16'd0;
        error_count_nxt    = 8'd0;
        first_seen_nxt     = 1'b0;
        write_address_nxt  = image_base_r;
      end
      ACT_BYTE, ACT_TIMEOUT: begin
        if (phase_r == PH_HEADER) begin
          // 'C' invitation before the first block
          if (!is_byte && !first_seen_r) begin
            item = '0; item.tx_valid = 1'b1; item.tx_byte = B_C;
            res[nres] = item; nres = nres + 2'd1;
          end
          if (error_count_r >= error_limit_r) begin
            // error limit reached: CAN CAN
            item = '0; item.tx_valid = 1'b1; item.tx_byte = B_CAN;
            res[nres] = item; nres = nres + 2'd1;
            item.aborted = 1'b1;
            res[nres] = item; nres = nres + 2'd1;
            phase_nxt = PH_ABORT;
          end else if (is_byte) begin
            if (in_rx_byte == B_SOH || in_rx_byte == B_STX) begin
              long_block_nxt  = (in_rx_byte == B_STX);
              byte_count_nxt  = 11'd0;
              running_crc_nxt = 16'd0;
              sent_crc_nxt    = 16'd0;
              phase_nxt       = PH_NUMBER;
              if (!first_seen_r) begin
                first_seen_nxt = 1'b1;
                item = '0; item.erase_request = 1'b1;
                res[nres] = item; nres = nres + 2'd1;
              end
            end else if (in_rx_byte == B_EOT) begin
              item = '0; item.tx_valid = 1'b1; item.tx_byte = B_ACK; item.finished = 1'b1;
              res[nres] = item; nres = nres + 2'd1;
              phase_nxt = PH_DONE;
            end else if (in_rx_byte == B_CAN) begin
              item = '0; item.aborted = 1'b1;
              res[nres] = item; nres = nres + 2'd1;
              phase_nxt = PH_ABORT;
            end else begin
              item = '0; item.tx_valid = 1'b1; item.tx_byte = B_NAK;
              res[nres] = item; nres = nres + 2'd1;
              if (error_count_r != ERR_SATURATE) error_count_nxt = error_count_r + 8'd1;
            end
          end
        end else if (phase_r != PH_DONE && phase_r != PH_ABORT) begin
          // inside a block
          item = '0; item.tx_valid = 1'b1; item.tx_byte = B_NAK; item.block_end = 1'b1;
          if (!is_byte) begin
            res[nres] = item; nres = nres + 2'd1;
            if (error_count_r != ERR_SATURATE) error_count_nxt = error_count_r + 8'd1;
            phase_nxt = PH_HEADER;
          end else begin
            case (phase_r)
              PH_NUMBER: begin
                got_number_nxt = in_rx_byte;
                phase_nxt      = PH_COMPL;
              end
              PH_COMPL: begin
                got_complement_nxt = in_rx_byte;
                phase_nxt          = PH_DATA;
              end
              PH_DATA: begin
                item = '0;
                item.data_valid   = 1'b1;
                item.data_byte    = in_rx_byte;
                item.data_address = write_address_r + {21'd0, byte_count_r};
                res[nres] = item; nres = nres + 2'd1;
                running_crc_nxt = crc_byte(running_crc_r, in_rx_byte);
                byte_count_nxt  = count_inc;
                if (count_inc >= blk_size) phase_nxt = PH_CRC_HI;
              end
              PH_CRC_HI: begin
                sent_crc_nxt = {in_rx_byte, 8'h00};
                phase_nxt    = PH_CRC_LO;
              end
              default: begin
                // last CRC byte: verify the block
                sent_crc_nxt = sent_full;
                phase_nxt    = PH_HEADER;
                if (got_number_r == expected_block_r &&
                    ({1'b0, got_number_r} + {1'b0, got_complement_r}) == NUM_SUM &&
                    sent_full == running_crc_r) begin
                  item.tx_byte    = B_ACK;
                  item.block_good = 1'b1;
                  expected_block_nxt = expected_block_r + 8'd1;
                  write_address_nxt  = write_address_r + {21'd0, blk_size};
                end else begin
                  if (error_count_r != ERR_SATURATE) error_count_nxt = error_count_r + 8'd1;
                end
                res[nres] = item; nres = nres + 2'd1;
              end
            endcase
          end
        end
      end
      default: begin
        // reserved action: ignored
      end
    endcase

    if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_limit_r <= ERROR_LIMIT_RST;
      image_base_r  <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ERROR_LIMIT: error_limit_r <= cfg_data[7:0];
        CFG_IMAGE_BASE:  image_base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Protocol state update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HEADER;
      expected_block_r <= 8'd1;
      got_number_r     <= 8'd0;
      got_complement_r <= 8'd0;
      long_block_r     <= 1'b0;
      byte_count_r     <= 11'd0;
      running_crc_r    <= 16'd0;
      sent_crc_r       <= 16'd0;
      error_count_r    <= 8'd0;
      first_seen_r     <= 1'b0;
      write_address_r  <= 32'd0;
    end else if (in_acc) begin
      phase_r          <= phase_nxt;
      expected_block_r <= expected_block_nxt;
      got_number_r     <= got_number_nxt;
      got_complement_r <= got_complement_nxt;
      long_block_r     <= long_block_nxt;
      byte_count_r     <= byte_count_nxt;
      running_crc_r    <= running_crc_nxt;
      sent_crc_r       <= sent_crc_nxt;
      error_count_r    <= error_count_nxt;
      first_seen_r     <= first_seen_nxt;
      write_address_r  <= write_address_nxt;
    end
  end

  // Result buffer count
  always_comb begin
    if (in_acc) cnt_nxt = nres;
    else if (out_acc) cnt_nxt = cnt_r - 2'd1;
    else cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result buffer payload: load on accept, shift on pop
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r[0] <= res[0];
      slot_r[1] <= res[1];
      slot_r[2] <= res[2];
    end else if (out_acc) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // Output fields
  assign out_tx_valid      = slot_r[0].tx_valid;
  assign out_tx_byte       = slot_r[0].tx_byte;
  assign out_data_valid    = slot_r[0].data_valid;
  assign out_data_byte     = slot_r[0].data_byte;
  assign out_data_address  = slot_r[0].data_address;
  assign out_block_end     = slot_r[0].block_end;
  assign out_block_good    = slot_r[0].block_good;
  assign out_erase_request = slot_r[0].erase_request;
  assign out_finished      = slot_r[0].finished;
  assign out_aborted       = slot_r[0].aborted;
  assign out_last          = slot_r[0].last;

`ifndef SYNTH
  // Finish is always a lone ACK
  a_finish_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_tx_valid && out_tx_byte == B_ACK && out_last)
    else $error("finish without ACK");

  // A good block is acknowledged
  a_good_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end && out_block_good |-> out_tx_byte == B_ACK)
    else $error("good block without ACK");

  // After finish or abort, bytes and timeouts produce nothing
  a_quiet_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action != ACT_START && (phase_r == PH_DONE || phase_r == PH_ABORT)
    |=> cnt_r == 2'd0)
    else $error("result after transfer end");

  // Payload items carry no reply byte
  a_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> !out_tx_valid && !out_block_end)
    else $error("payload item mixed with reply");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the XMODEM-CRC receive engine
// A clocked driver feeds host bytes, timeouts and session starts from a
// queue. A bit-accurate tracker of the receiver predicts every reply,
// payload byte and status transaction. A clocked monitor compares each
// result with the oldest prediction, field by field. Both sides stall at
// random except in the last third of the random run, and the run walks
// through several error-limit and image-base settings.
// ---------------------------------------------------------------------------
module tb_top;
  import xcrc_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int RANDOM_ITEMS  = 370;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } host_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_data_valid;
  logic [7:0]  out_data_byte;
  logic [31:0] out_data_address;
  logic        out_block_end;
  logic        out_block_good;
  logic        out_erase_request;
  logic        out_finished;
  logic        out_aborted;
  logic        out_last;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  xmodem_crc_receiver_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_data_valid    (out_data_valid),
    .out_data_byte     (out_data_byte),
    .out_data_address  (out_data_address),
    .out_block_end     (out_block_end),
    .out_block_good    (out_block_good),
    .out_erase_request (out_erase_request),
    .out_finished      (out_finished),
    .out_aborted       (out_aborted),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Host-side byte stream and predicted receiver outcomes
  host_item_t host_stream [$];
  res_t       rx_outcomes [$];

  // Bookkeeping
  int n_pushed;
  int n_accepted;
  int n_results;
  int stim_count;
  int n_settings;
  int mismatches;
  int good_blocks;
  int bad_blocks;
  int quiet_cycles;
  bit count_on;
  int sender_idle_pct;
  int receiver_idle_pct;

  // Receiver tracker: configuration copy and session state
  logic [7:0]  lim_cfg;
  logic [31:0] base_cfg;
  logic [2:0]  rx_phase;
  logic [7:0]  exp_blk;
  logic [7:0]  got_num;
  logic [7:0]  got_cmp;
  logic        long_blk;
  logic [10:0] byte_cnt;
  logic [15:0] crc_run;
  logic [15:0] crc_sent;
  logic [7:0]  err_count;
  logic        first_hdr;
  logic [31:0] wr_addr;
  res_t        step_out [0:2];
  int          n_out;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-16/XMODEM, serial form, one byte MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic res_t tx_only(input logic [7:0] b);
    res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    return r;
  endfunction

  task automatic emit(input res_t r);
    if (n_out < 3) step_out[n_out] = r;
    n_out++;
  endtask

  task automatic session_restart();
    rx_phase  = PH_HEADER;
    exp_blk   = 8'd1;
    got_num   = 8'd0;
    got_cmp   = 8'd0;
    long_blk  = 1'b0;
    byte_cnt  = 11'd0;
    crc_run   = 16'h0000;
    crc_sent  = 16'h0000;
    err_count = 8'd0;
    first_hdr = 1'b0;
    wr_addr   = base_cfg;
  endtask

  task automatic bump_errors();
    if (err_count != ERR_SATURATE) err_count++;
  endtask

  task automatic reject_block();
    res_t r;
    r = tx_only(B_NAK);
    r.block_end = 1'b1;
    emit(r);
    bump_errors();
    rx_phase = PH_HEADER;
  endtask

  // Waiting for a header: 'C' polling, limit abort, block open, EOT, CAN
  task automatic header_item(input bit is_byte, input logic [7:0] b);
    res_t r;
    if (!is_byte && !first_hdr) emit(tx_only(B_C));
    if (err_count >= lim_cfg) begin
      emit(tx_only(B_CAN));
      r = tx_only(B_CAN);
      r.aborted = 1'b1;
      emit(r);
      rx_phase = PH_ABORT;
    end else if (is_byte) begin
      if (b == B_SOH || b == B_STX) begin
        long_blk = (b == B_STX);
        byte_cnt = 11'd0;
        crc_run  = 16'h0000;
        crc_sent = 16'h0000;
        rx_phase = PH_NUMBER;
        if (!first_hdr) begin
          first_hdr = 1'b1;
          r = '0;
          r.erase_request = 1'b1;
          emit(r);
        end
      end else if (b == B_EOT) begin
        r = tx_only(B_ACK);
        r.finished = 1'b1;
        emit(r);
        rx_phase = PH_DONE;
      end else if (b == B_CAN) begin
        r = '0;
        r.aborted = 1'b1;
        emit(r);
        rx_phase = PH_ABORT;
      end else begin
        emit(tx_only(B_NAK));
        bump_errors();
      end
    end
  endtask

  // Inside a block: number, complement, payload, CRC and the verdict
  task automatic block_item(input logic [7:0] b);
    logic [10:0] blk_len;
    res_t        r;
    blk_len = long_blk ? LONG_BLOCK : SHORT_BLOCK;
    case (rx_phase)
      PH_NUMBER: begin
        got_num = b;
        rx_phase = PH_COMPL;
      end
      PH_COMPL: begin
        got_cmp = b;
        rx_phase = PH_DATA;
      end
      PH_DATA: begin
        r = '0;
        r.data_valid = 1'b1;
        r.data_byte = b;
        r.data_address = wr_addr + {21'd0, byte_cnt};
        emit(r);
        crc_run = crc_step(crc_run, b);
        byte_cnt = byte_cnt + 11'd1;
        if (byte_cnt >= blk_len) rx_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_sent = {b, 8'h00};
        rx_phase = PH_CRC_LO;
      end
      default: begin
        crc_sent = {crc_sent[15:8], b};
        if (got_num == exp_blk && ({1'b0, got_num} + {1'b0, got_cmp}) == NUM_SUM &&
            crc_sent == crc_run) begin
          r = tx_only(B_ACK);
          r.block_end = 1'b1;
          r.block_good = 1'b1;
          emit(r);
          exp_blk = exp_blk + 8'd1;
          wr_addr = wr_addr + {21'd0, blk_len};
          rx_phase = PH_HEADER;
        end else begin
          reject_block();
        end
      end
    endcase
  endtask

  // One accepted input transaction: predict its result transactions
  task automatic advance_receiver(input logic [1:0] act, input logic [7:0] b);
    n_out = 0;
    if (act == ACT_START) begin
      session_restart();
    end else if (act == ACT_BYTE || act == ACT_TIMEOUT) begin
      if (rx_phase == PH_HEADER) begin
        header_item(act == ACT_BYTE, b);
      end else if (rx_phase >= PH_NUMBER && rx_phase <= PH_CRC_LO) begin
        if (act == ACT_BYTE) block_item(b);
        else reject_block();
      end
    end
    if (n_out > 0) step_out[n_out-1].last = 1'b1;
    for (int i = 0; i < n_out; i++) rx_outcomes.push_back(step_out[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver
  always @(posedge clk) begin : host_driver
    host_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_receiver(in_action, in_rx_byte);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (host_stream.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = host_stream.pop_front();
          in_valid   <= 1'b1;
          in_action  <= nxt.action;
          in_rx_byte <= nxt.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (rx_outcomes.size() == 0) begin
          $error("unexpected result transaction: tx %0b/%0h data %0b/%0h",
                 out_tx_valid, out_tx_byte, out_data_valid, out_data_byte);
          mismatches++;
        end else begin
          want = rx_outcomes.pop_front();
          check_field("tx_valid", 32'(want.tx_valid), 32'(out_tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(out_tx_byte));
          check_field("data_valid", 32'(want.data_valid), 32'(out_data_valid));
          check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
          check_field("data_address", want.data_address, out_data_address);
          check_field("block_end", 32'(want.block_end), 32'(out_block_end));
          check_field("block_good", 32'(want.block_good), 32'(out_block_good));
          check_field("erase_request", 32'(want.erase_request), 32'(out_erase_request));
          check_field("finished", 32'(want.finished), 32'(out_finished));
          check_field("aborted", 32'(want.aborted), 32'(out_aborted));
          check_field("last", 32'(want.last), 32'(out_last));
          if (want.block_end) begin
            if (want.block_good) good_blocks++;
            else bad_blocks++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus helpers
  task automatic push_item(input logic [1:0] act, input logic [7:0] b);
    host_item_t it;
    it.action = act;
    it.rx_byte = b;
    host_stream.push_back(it);
    n_pushed++;
    if (count_on) stim_count++;
  endtask

  task automatic push_ignored(input logic [1:0] act, input logic [7:0] b);
    count_on = 1'b0;
    push_item(act, b);
    count_on = 1'b1;
  endtask

  // Full block with random payload; crc_flip corrupts the CRC, cut_crc
  // replaces the low CRC byte by a timeout
  task automatic push_block(input bit is_long, input logic [7:0] num, input logic [7:0] cmp,
                            input logic [15:0] crc_flip, input bit cut_crc);
    logic [15:0] acc;
    logic [7:0]  d;
    int          len;
    len = is_long ? 1024 : 128;
    acc = 16'h0000;
    push_item(ACT_BYTE, is_long ? B_STX : B_SOH);
    push_item(ACT_BYTE, num);
    push_item(ACT_BYTE, cmp);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(255));
      acc = crc_step(acc, d);
      push_item(ACT_BYTE, d);
    end
    acc = acc ^ crc_flip;
    push_item(ACT_BYTE, acc[15:8]);
    if (cut_crc) push_item(ACT_TIMEOUT, 8'($urandom_range(255)));
    else push_item(ACT_BYTE, acc[7:0]);
  endtask

  // Block broken off by a timeout somewhere before its payload ends
  task automatic push_cut_block(input logic [7:0] num);
    int cut;
    cut = $urandom_range(14);
    push_item(ACT_BYTE, ($urandom_range(1) == 1) ? B_STX : B_SOH);
    if (cut >= 1) push_item(ACT_BYTE, num);
    if (cut >= 2) push_item(ACT_BYTE, ~num);
    for (int i = 3; i <= cut; i++) push_item(ACT_BYTE, 8'($urandom_range(255)));
    push_item(ACT_TIMEOUT, 8'($urandom_range(255)));
  endtask

  // One session: well-formed blocks, plus broken blocks, timeouts and noise;
  // new operations stop once the stimulus count reaches stop_at
  task automatic fill_session(input logic [7:0] lim, input int stop_at);
    logic [7:0] next_num;
    logic [7:0] junk;
    int         errs;
    int         n_ops;
    int         pick;
    next_num = 8'd1;
    errs = 0;
    n_ops = $urandom_range(3, 6);
    push_item(ACT_START, 8'($urandom_range(255)));
    for (int k = 0; k < n_ops && errs < lim && stim_count < stop_at; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_block(1'b0, next_num, ~next_num, 16'h0000, 1'b0);
        next_num++;
      end else if (pick < 52) begin
        case ($urandom_range(4))
          0: begin
            junk = next_num + 8'($urandom_range(1, 254));
            push_block(1'b0, junk, ~junk, 16'h0000, 1'b0);
          end
          1: push_block(1'b0, next_num - 8'd1, ~(next_num - 8'd1), 16'h0000, 1'b0);
          2: push_block(1'b0, next_num, ~next_num ^ 8'($urandom_range(1, 255)), 16'h0000, 1'b0);
          3: push_block(1'b0, next_num, ~next_num, 16'($urandom_range(1, 65535)), 1'b0);
          default: push_block(1'b0, next_num, ~next_num, 16'h0000, 1'b1);
        endcase
        errs++;
      end else if (pick < 70) begin
        push_cut_block(next_num);
        errs++;
      end else if (pick < 80) begin
        do junk = 8'($urandom_range(255));
        while (junk == B_SOH || junk == B_STX || junk == B_EOT || junk == B_CAN);
        push_item(ACT_BYTE, junk);
        errs++;
      end else if (pick < 92) begin
        push_item(ACT_TIMEOUT, 8'($urandom_range(255)));
      end else begin
        push_ignored(ACT_UNUSED, 8'($urandom_range(255)));
      end
    end
    // Close the session: limit abort, EOT or host cancel
    if (errs >= lim) push_item(($urandom_range(1) == 1) ? ACT_TIMEOUT : ACT_BYTE, B_SOH);
    else if ($urandom_range(99) < 70) push_item(ACT_BYTE, B_EOT);
    else push_item(ACT_BYTE, B_CAN);
    push_ignored(($urandom_range(1) == 1) ? ACT_TIMEOUT : ACT_BYTE, 8'($urandom_range(255)));
  endtask

  // Wait until every transaction is through and the block has settled
  task automatic wait_idle();
    while (n_accepted != n_pushed || rx_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] lim, input logic [31:0] base);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ERROR_LIMIT;
    cfg_data  <= {24'd0, lim};
    @(posedge clk);
    cfg_index <= CFG_IMAGE_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_cfg = lim;
    base_cfg = base;
    n_settings++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_idle_pct = 17; receiver_idle_pct = 81; end
      1: begin sender_idle_pct = 81; receiver_idle_pct = 17; end
      default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
    endcase
  endtask

  // Main sequence
  initial begin
    logic [7:0]  lim;
    logic [31:0] base;
    int          phase_idx;
    int          stop_at;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_START;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ERROR_LIMIT;
    cfg_data = 32'd0;
    n_pushed = 0;
    n_accepted = 0;
    n_results = 0;
    stim_count = 0;
    n_settings = 0;
    mismatches = 0;
    good_blocks = 0;
    bad_blocks = 0;
    quiet_cycles = 0;
    count_on = 1'b0;
    set_idling(0);
    lim_cfg = ERROR_LIMIT_RST;
    base_cfg = 32'd0;
    session_restart();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero error limit aborts on the first header-phase timeout
    program_regs(8'd0, 32'd0);
    push_item(ACT_START, 8'h00);
    push_item(ACT_TIMEOUT, 8'h00);
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_UNUSED, 8'h00);
    wait_idle();

    // Directed: polling, bad headers, limit abort, timeouts inside blocks,
    // EOT, host cancel and items after the end of a transfer
    program_regs(8'd2, 32'h0000_8000);
    push_item(ACT_START, 8'hFF);
    push_item(ACT_TIMEOUT, 8'hFF);
    push_item(ACT_BYTE, 8'h00);
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_TIMEOUT, 8'h00);
    push_item(ACT_START, 8'h00);
    push_item(ACT_BYTE, B_SOH);
    push_item(ACT_BYTE, 8'h01);
    push_item(ACT_BYTE, 8'hFE);
    push_item(ACT_BYTE, 8'hAA);
    push_item(ACT_TIMEOUT, 8'h00);
    push_item(ACT_TIMEOUT, 8'h00);
    push_item(ACT_BYTE, B_STX);
    push_item(ACT_BYTE, 8'h05);
    push_item(ACT_UNUSED, 8'hFF);
    push_item(ACT_TIMEOUT, 8'h00);
    push_item(ACT_BYTE, B_EOT);
    push_item(ACT_START, 8'h00);
    push_item(ACT_BYTE, B_EOT);
    push_item(ACT_TIMEOUT, 8'h00);
    push_item(ACT_START, 8'h00);
    push_item(ACT_BYTE, B_CAN);
    wait_idle();

    // Random sessions under changing limits and image bases; each third
    // of the stimulus runs under its own idling pattern
    count_on = 1'b1;
    phase_idx = 0;
    while (stim_count < RANDOM_ITEMS) begin
      case (phase_idx)
        0: begin lim = 8'd255; base = 32'hFFFF_FFC0; end
        1: begin lim = 8'd1; base = 32'hFFFF_FFFF; end
        2: begin lim = ERROR_LIMIT_RST; base = $urandom; end
        default: begin lim = 8'($urandom_range(2, 8)); base = $urandom; end
      endcase
      if (stim_count < RANDOM_ITEMS / 3) begin
        set_idling(0);
        stop_at = RANDOM_ITEMS / 3;
      end else if (stim_count < 2 * RANDOM_ITEMS / 3) begin
        set_idling(1);
        stop_at = 2 * RANDOM_ITEMS / 3;
      end else begin
        set_idling(2);
        stop_at = RANDOM_ITEMS;
      end
      program_regs(lim, base);
      fill_session(lim, stop_at);
      wait_idle();
      phase_idx++;
    end

    $display("Run covered %0d input and %0d result transactions under %0d register settings",
             n_accepted, n_results, n_settings);
    $display("Blocks acknowledged: %0d, rejected: %0d, field mismatches: %0d",
             good_blocks, bad_blocks, mismatches);
    if (mismatches == 0 && rx_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
